// ===== src/base64_stream_codec_macros.svh =====
// Assertion macros shared by the Base64 stream codec RTL.
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, checked on every clock out of reset.
`define B64SC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock out of reset.
`define B64SC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/b64sc_pkg.sv =====
// Types, character constants and alphabet functions of the Base64 stream codec.
`timescale 1ns / 1ps

package b64sc_pkg;

    localparam int unsigned MAX_RES = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;
    localparam logic [5:0] VAL_LOWER  = 6'd26;
    localparam logic [5:0] VAL_DIGIT  = 6'd52;

    // Per-string state.
    typedef struct packed {
        logic [11:0] acc;
        logic [3:0]  pb;
        logic [1:0]  cm;
        logic        fs;
        logic        ab;
    } t_st;

    // One result item.
    typedef struct packed {
        logic [7:0] sym;
        logic       dat;
        logic       last;
        logic       nb;
    } t_res;

    // 6-bit value to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < VAL_LOWER) begin
            c = CH_UPPER_A + {2'b00, v};
        end else if (v < VAL_DIGIT) begin
            c = CH_LOWER_A + {2'b00, v - VAL_LOWER};
        end else if (v < VAL_PLUS) begin
            c = CH_DIGIT_0 + {2'b00, v - VAL_DIGIT};
        end else if (v == VAL_PLUS) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

    // Character to {not_alphabet, 6-bit value}.
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            r = {1'b0, 6'(c - CH_UPPER_A)};
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            r = {1'b0, 6'(c - CH_LOWER_A + 8'(VAL_LOWER))};
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            r = {1'b0, 6'(c - CH_DIGIT_0 + 8'(VAL_DIGIT))};
        end else if (c == CH_PLUS) begin
            r = {1'b0, VAL_PLUS};
        end else if (c == CH_SLASH) begin
            r = {1'b0, VAL_SLASH};
        end
        return r;
    endfunction

endpackage

// ===== src/b64sc_xlate.sv =====
// Single-pass translation of one item into up to four results and the next string state.
`timescale 1ns / 1ps

module b64sc_xlate (
    input  logic                 i_mode,
    input  b64sc_pkg::t_st       i_st,
    input  logic [7:0]           i_sym,
    input  logic                 i_last,
    output b64sc_pkg::t_st       o_st,
    output b64sc_pkg::t_res      o_res [b64sc_pkg::MAX_RES],
    output logic [2:0]           o_cnt
);

    logic [11:0] acc_e;
    logic [11:0] acc_d;
    logic [5:0]  c0;
    logic [5:0]  c1;
    logic [5:0]  flush;
    logic [3:0]  npb;
    logic [3:0]  pb1;
    logic [3:0]  pb2;
    logic [2:0]  cnt;
    logic [2:0]  pads;
    logic [1:0]  cm1;
    logic [6:0]  dv;
    logic        fs1;
    logic        ab1;

    always_comb begin
        for (int k = 0; k < b64sc_pkg::MAX_RES; k++) begin
            o_res[k] = '0;
        end
        o_st  = i_st;
        acc_e = {i_st.acc[3:0], i_sym};
        acc_d = '0;
        c0    = '0;
        c1    = '0;
        flush = '0;
        npb   = '0;
        pb1   = '0;
        pb2   = '0;
        cnt   = '0;
        pads  = '0;
        cm1   = i_st.cm;
        dv    = b64sc_pkg::dec_char(i_sym);
        fs1   = i_st.fs;
        ab1   = i_st.ab;

        if (i_mode) begin
            // Encode: zero, two or four leftover bits plus the byte give one or two characters.
            case (i_st.pb)
                4'd2: begin
                    c0 = acc_e[9:4]; npb = 4'd4; cnt = 3'd1;
                end
                4'd4: begin
                    c0 = acc_e[11:6]; c1 = acc_e[5:0]; npb = 4'd0; cnt = 3'd2;
                end
                default: begin
                    c0 = acc_e[7:2]; npb = 4'd2; cnt = 3'd1;
                end
            endcase
            o_res[0] = '{sym: b64sc_pkg::enc_char(c0), dat: 1'b1, last: 1'b0, nb: 1'b0};
            o_res[1] = '{sym: b64sc_pkg::enc_char(c1), dat: 1'b1, last: 1'b0, nb: 1'b0};
            cm1 = i_st.cm + cnt[1:0];
            o_st.acc = acc_e;
            o_st.pb  = npb;
            o_st.cm  = cm1;
            if (i_last) begin
                // Flush leftover bits zero-filled, then pad to a multiple of four.
                flush = (npb == 4'd2) ? {acc_e[1:0], 4'b0000} : {acc_e[3:0], 2'b00};
                if (npb != 4'd0) begin
                    for (int k = 0; k < b64sc_pkg::MAX_RES; k++) begin
                        if (3'(k) == cnt) begin
                            o_res[k] = '{sym: b64sc_pkg::enc_char(flush), dat: 1'b1,
                                         last: 1'b0, nb: 1'b0};
                        end
                    end
                    cnt = cnt + 3'd1;
                    cm1 = cm1 + 2'd1;
                end
                pads = {1'b0, 2'(2'd0 - cm1)};
                for (int k = 0; k < b64sc_pkg::MAX_RES; k++) begin
                    if (3'(k) >= cnt && 3'(k) < cnt + pads) begin
                        o_res[k] = '{sym: b64sc_pkg::CH_PAD, dat: 1'b1, last: 1'b0, nb: 1'b0};
                    end
                end
                cnt = cnt + pads;
                for (int k = 0; k < b64sc_pkg::MAX_RES; k++) begin
                    if (3'(k) == cnt - 3'd1) begin
                        o_res[k].last = 1'b1;
                    end
                end
                o_st = '0;
            end
        end else begin
            // Decode: skip anything outside the alphabet, emit a byte once eight bits collect.
            if (dv[6]) begin
                if (i_sym != b64sc_pkg::CH_PAD) begin
                    fs1 = 1'b1;
                end
            end else begin
                acc_d = {i_st.acc[5:0], dv[5:0]};
                pb1   = i_st.pb + 4'd6;
                o_st.acc = acc_d;
                o_st.pb  = pb1;
                if (pb1 >= 4'd8) begin
                    pb2 = pb1 - 4'd8;
                    o_st.pb = pb2;
                    ab1 = 1'b1;
                    o_res[0] = '{sym: 8'(acc_d >> pb2), dat: 1'b1, last: 1'b0, nb: 1'b0};
                    cnt = 3'd1;
                end
            end
            o_st.fs = fs1;
            o_st.ab = ab1;
            if (i_last) begin
                // An end-only marker stands in when no byte came out.
                cnt = 3'd1;
                o_res[0].last = 1'b1;
                o_res[0].nb   = fs1 | ~ab1;
                o_st = '0;
            end
        end
        o_cnt = cnt;
    end

endmodule

// ===== src/b64sc_resbuf.sv =====
// Result register file: holds the results of one item and hands them out one per cycle while not stalled.
`timescale 1ns / 1ps

module b64sc_resbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  b64sc_pkg::t_res      i_res [b64sc_pkg::MAX_RES],
    input  logic [2:0]           i_cnt,
    input  logic                 i_stall,
    output logic                 o_valid,
    output b64sc_pkg::t_res      o_res,
    output logic                 o_free
);

    b64sc_pkg::t_res r_ent [b64sc_pkg::MAX_RES];
    logic [2:0]      r_cnt;
    logic [1:0]      r_rd;
    logic [2:0]      n_cnt;
    logic [1:0]      n_rd;
    logic            take;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_ent[r_rd];
    assign take    = o_valid & ~i_stall;
    // Free when empty or once the last held result leaves this cycle.
    assign o_free  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && take);

    always_comb begin
        n_cnt = r_cnt;
        n_rd  = r_rd;
        if (i_load) begin
            n_cnt = i_cnt;
            n_rd  = 2'd0;
        end else if (take) begin
            n_cnt = r_cnt - 3'd1;
            n_rd  = r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res;
        end
    end

endmodule

// ===== src/base64_stream_codec.sv =====
// Top level of the Base64 stream codec: input register, string state, config and checks.
`timescale 1ns / 1ps

// Base64 (standard alphabet) stream codec, one symbol per item with a last
// flag. Mode register: 1 encodes bytes into text padded with '=', 0 decodes
// text into bytes, skipping characters outside the alphabet and flagging
// foreign characters or an empty result on the final result of the string.
// Accepted items land in an input register; one pass of logic turns the item
// into all of its results (encode one to four, decode zero or one, an
// end-only marker with out_valid low closing a decode string that ends
// without a byte) and loads them into the result buffer once it is free.
// The result buffer drains one result per cycle while i_res_stall is low,
// and takes the next item only when its last result leaves; an encode item
// makes on average 4/3 results over a long string. Items that make no
// result pass at one per cycle. A config write clears the string state and
// must only be made while the block is idle.
`include "base64_stream_codec_macros.svh"

module base64_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input items
    input  logic       i_item_valid,
    output logic       o_item_stall,
    input  logic [7:0] i_in_symbol,
    input  logic       i_in_last,
    // result items
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_symbol,
    output logic       o_out_valid,
    output logic       o_out_last,
    output logic       o_not_base64
);

    logic            r_mode;
    logic            r_in_vld;
    logic [7:0]      r_in_sym;
    logic            r_in_last;
    b64sc_pkg::t_st  r_st;

    logic            n_in_vld;
    b64sc_pkg::t_st  n_st;

    b64sc_pkg::t_st  xl_st;
    b64sc_pkg::t_res xl_res [b64sc_pkg::MAX_RES];
    logic [2:0]      xl_cnt;
    b64sc_pkg::t_res buf_res;
    logic            buf_free;
    logic            accept;
    logic            adv;

    // Config writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Advance the input register into the result buffer once it can take a whole item.
    assign adv          = r_in_vld & buf_free;
    assign o_item_stall = r_in_vld & ~buf_free;
    assign accept       = i_item_valid & ~o_item_stall;

    b64sc_xlate u_xlate (
        .i_mode (r_mode),
        .i_st   (r_st),
        .i_sym  (r_in_sym),
        .i_last (r_in_last),
        .o_st   (xl_st),
        .o_res  (xl_res),
        .o_cnt  (xl_cnt)
    );

    b64sc_resbuf u_resbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (xl_res),
        .i_cnt   (xl_cnt),
        .i_stall (i_res_stall),
        .o_valid (o_res_valid),
        .o_res   (buf_res),
        .o_free  (buf_free)
    );

    assign o_out_symbol = buf_res.sym;
    assign o_out_valid  = buf_res.dat;
    assign o_out_last   = buf_res.last;
    assign o_not_base64 = buf_res.nb;

    always_comb begin
        n_in_vld = accept | (r_in_vld & ~adv);
        n_st     = r_st;
        // A config write aborts the string; it wins over an item in flight.
        if (i_cfg_valid) begin
            n_st = '0;
        end else if (adv) begin
            n_st = xl_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_in_vld <= 1'b0;
            r_st     <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            r_st     <= n_st;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // Hold payload until the next accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_sym  <= i_in_symbol;
            r_in_last <= i_in_last;
        end
    end

    `B64SC_ASSERT_IMP(a_marker_is_last, o_res_valid && !o_out_valid, o_out_last,
        "end-only marker without last")
    `B64SC_ASSERT_IMP(a_enc_res_clean, adv && r_mode,
        xl_res[0].dat && !xl_res[0].nb && xl_cnt != 3'd0, "encode item made bad result")
    `B64SC_ASSERT_IMP(a_pb_range, 1'b1,
        !r_st.pb[0] && r_st.pb <= 4'd6 && (!r_mode || r_st.pb != 4'd6),
        "pending bit count out of range")
    `B64SC_ASSERT_NXT(a_cfg_clears, i_cfg_valid,
        r_st.pb == 4'd0 && r_st.cm == 2'd0 && !r_st.fs, "config write left string state")

endmodule
